@@ sv/ftpr_pkg.sv @@
// Shared types, codes and constants of the fat tree port router.
`default_nettype none

package ftpr_pkg;

    // Widest port count the 6-bit port field can name.
    localparam int HW_PORT_LIMIT = 64;
    localparam int MAX_PORTS_DEFAULT = 64;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 6;
    localparam int COUNT_W = 7;
    localparam int LEVEL_W = 2;
    localparam int HOSTS_W = 6;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROUTER_LEVEL = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOSTS_ATTACHED = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BROADCAST_ADDRESS = 3'd4;

    // Register reset values.
    localparam logic [COUNT_W-1:0] PORT_COUNT_RESET = 7'd8;
    localparam logic [LEVEL_W-1:0] ROUTER_LEVEL_RESET = 2'd1;
    localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET = 32'h0000_0000;
    localparam logic [HOSTS_W-1:0] HOSTS_ATTACHED_RESET = 6'd4;
    localparam logic [ADDR_W-1:0] BROADCAST_ADDRESS_RESET = 32'hffff_ffff;

    // Tree levels.
    localparam logic [LEVEL_W-1:0] LEVEL_EDGE = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_AGGREGATION = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_CORE = 2'd3;

    // Opcodes.
    localparam logic OP_ROUTE = 1'b0;
    localparam logic OP_INIT = 1'b1;

    // Upstream and host address bytes start at this value.
    localparam logic [7:0] BYTE_OFFSET = 8'd2;
    // Core level matches this value in address byte 0.
    localparam logic [7:0] CORE_NET_BYTE = 8'd10;

    typedef enum logic [1:0] {
        STATUS_PORT     = 2'd0,
        STATUS_NO_MATCH = 2'd1,
        STATUS_EMPTY    = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_FLOOD = 1'b1
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic take_unicast;
        logic start_flood;
        logic emit_flood;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;
        logic is_bcast;
        logic flood_last;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/ftpr_dp.sv @@
// Datapath of the fat tree port router: registers, port decode, flood walker, output beat.
`default_nettype none

module ftpr_dp #(
    parameter int MAX_PORTS = ftpr_pkg::MAX_PORTS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [ftpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ftpr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               opcode,
    input  wire logic [ftpr_pkg::ADDR_W-1:0]        destination,
    input  wire logic [ftpr_pkg::PORT_W-1:0]        arrival_port,
    input  wire logic                               out_ready,
    input  wire ftpr_pkg::dp_cmd_t                  cmd,
    output ftpr_pkg::dp_stat_t                      stat,
    output logic                                    out_valid,
    output logic [ftpr_pkg::PORT_W-1:0]             out_port,
    output logic [1:0]                              status,
    output logic                                    last_of_run
);

    localparam int PORT_LIMIT = (MAX_PORTS < ftpr_pkg::HW_PORT_LIMIT) ?
                                MAX_PORTS : ftpr_pkg::HW_PORT_LIMIT;
    localparam logic [ftpr_pkg::COUNT_W-1:0] PORT_LIMIT_W = ftpr_pkg::COUNT_W'(PORT_LIMIT);

    // Configuration registers.
    logic [ftpr_pkg::COUNT_W-1:0] port_count_reg;
    logic [ftpr_pkg::LEVEL_W-1:0] router_level_reg;
    logic [ftpr_pkg::ADDR_W-1:0]  own_address_reg;
    logic [ftpr_pkg::HOSTS_W-1:0] hosts_attached_reg;
    logic [ftpr_pkg::ADDR_W-1:0]  broadcast_address_reg;

    // Flood walker.
    logic [ftpr_pkg::COUNT_W-1:0] flood_cur_reg, flood_cur_next;
    logic [ftpr_pkg::COUNT_W-1:0] flood_left_reg, flood_left_next;
    logic                         up_first_reg, up_first_next;
    logic                         up_last_reg, up_last_next;
    logic [ftpr_pkg::PORT_W-1:0]  arrive_reg, arrive_next;

    // Output beat.
    logic                         out_valid_reg, out_valid_next;
    logic [ftpr_pkg::PORT_W-1:0]  out_port_reg, out_port_next;
    ftpr_pkg::status_t            status_reg, status_next;
    logic                         last_reg, last_next;

    // Derived port geometry.
    logic [ftpr_pkg::COUNT_W-1:0] ports_used;
    logic [ftpr_pkg::PORT_W-1:0]  half;
    logic [ftpr_pkg::PORT_W-1:0]  hosts;
    logic [ftpr_pkg::COUNT_W-1:0] up_room;
    logic                         lvl_edge, lvl_aggr, lvl_core;

    // Unicast decode.
    logic [7:0]                   d0, d1, d2, d3, d3_off;
    logic                         d3_ok;
    logic                         host_hit, unwired_hit, aggr_hit, up_hit, core_hit;
    logic [ftpr_pkg::COUNT_W-1:0] up_sum;
    logic [ftpr_pkg::PORT_W-1:0]  uni_port;
    ftpr_pkg::status_t            uni_status;

    // Flood setup and step.
    logic [ftpr_pkg::COUNT_W-1:0] flood_lim;
    logic                         arrive_down, arrive_in_range;
    logic [ftpr_pkg::COUNT_W-1:0] flood_total;
    logic [ftpr_pkg::COUNT_W-1:0] range_port;

    always_comb
    begin
        ports_used = (port_count_reg > PORT_LIMIT_W) ? PORT_LIMIT_W : port_count_reg;
        half = ports_used[ftpr_pkg::COUNT_W-1:1];
        hosts = (hosts_attached_reg < half) ? hosts_attached_reg : half;
        up_room = ports_used - {1'b0, half};
        lvl_edge = (router_level_reg == ftpr_pkg::LEVEL_EDGE);
        lvl_aggr = (router_level_reg == ftpr_pkg::LEVEL_AGGREGATION);
        lvl_core = (router_level_reg == ftpr_pkg::LEVEL_CORE);
    end

    // The per-port mask table reduces to a direct decode of the destination bytes.
    always_comb
    begin
        d0 = destination[7:0];
        d1 = destination[15:8];
        d2 = destination[23:16];
        d3 = destination[31:24];
        d3_ok = (d3 >= ftpr_pkg::BYTE_OFFSET);
        d3_off = d3 - ftpr_pkg::BYTE_OFFSET;
        host_hit = lvl_edge && d3_ok && (d3_off < {2'b00, hosts})
                   && (destination[23:0] == own_address_reg[23:0]);
        unwired_hit = lvl_edge && (destination == '0) && (hosts < half);
        aggr_hit = lvl_aggr && (d2 < {2'b00, half})
                   && (destination[15:0] == own_address_reg[15:0]);
        up_hit = (lvl_edge || lvl_aggr) && d3_ok && (d3_off < {1'b0, up_room});
        core_hit = lvl_core && (d0 == ftpr_pkg::CORE_NET_BYTE) && (d1 < {1'b0, ports_used});
        up_sum = {1'b0, half} + d3_off[ftpr_pkg::COUNT_W-1:0];
        uni_status = ftpr_pkg::STATUS_PORT;
        if (host_hit)
        begin
            uni_port = d3_off[ftpr_pkg::PORT_W-1:0];
        end
        else if (unwired_hit)
        begin
            uni_port = hosts;
        end
        else if (aggr_hit)
        begin
            uni_port = d2[ftpr_pkg::PORT_W-1:0];
        end
        else if (up_hit)
        begin
            uni_port = up_sum[ftpr_pkg::PORT_W-1:0];
        end
        else if (core_hit)
        begin
            uni_port = d1[ftpr_pkg::PORT_W-1:0];
        end
        else
        begin
            uni_port = '0;
            uni_status = ftpr_pkg::STATUS_NO_MATCH;
        end
    end

    // A flood is an optional leading up port, a run of ports below a limit that skips
    // the arrival port, and an optional trailing up port.
    always_comb
    begin
        if (lvl_edge)
        begin
            flood_lim = {1'b0, hosts};
        end
        else if (lvl_aggr)
        begin
            flood_lim = {1'b0, half};
        end
        else if (lvl_core)
        begin
            flood_lim = ports_used;
        end
        else
        begin
            flood_lim = '0;
        end
        arrive_down = (arrival_port < half);
        arrive_in_range = ({1'b0, arrival_port} < flood_lim);
        flood_total = flood_lim - {6'd0, arrive_in_range}
                      + {6'd0, lvl_aggr && arrive_down} + {6'd0, lvl_edge && arrive_down};
        range_port = (flood_cur_reg == {1'b0, arrive_reg}) ? flood_cur_reg + 7'd1
                                                            : flood_cur_reg;
    end

    always_comb
    begin
        flood_cur_next = flood_cur_reg;
        flood_left_next = flood_left_reg;
        up_first_next = up_first_reg;
        up_last_next = up_last_reg;
        arrive_next = arrive_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_port_next = out_port_reg;
        status_next = status_reg;
        last_next = last_reg;

        if (cmd.take_unicast)
        begin
            out_valid_next = 1'b1;
            out_port_next = uni_port;
            status_next = uni_status;
            last_next = 1'b1;
        end

        if (cmd.start_flood)
        begin
            flood_cur_next = '0;
            flood_left_next = flood_total;
            up_first_next = lvl_aggr && arrive_down;
            up_last_next = lvl_edge && arrive_down;
            arrive_next = arrival_port;
        end

        if (cmd.emit_flood)
        begin
            out_valid_next = 1'b1;
            last_next = (flood_left_reg <= 7'd1);
            status_next = ftpr_pkg::STATUS_PORT;
            if (flood_left_reg == '0)
            begin
                out_port_next = '0;
                status_next = ftpr_pkg::STATUS_EMPTY;
            end
            else if (up_first_reg)
            begin
                out_port_next = half;
                up_first_next = 1'b0;
                flood_left_next = flood_left_reg - 7'd1;
            end
            else if (up_last_reg && (flood_left_reg == 7'd1))
            begin
                out_port_next = half;
                flood_left_next = '0;
            end
            else
            begin
                out_port_next = range_port[ftpr_pkg::PORT_W-1:0];
                flood_cur_next = range_port + 7'd1;
                flood_left_next = flood_left_reg - 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_count_reg <= ftpr_pkg::PORT_COUNT_RESET;
            router_level_reg <= ftpr_pkg::ROUTER_LEVEL_RESET;
            own_address_reg <= ftpr_pkg::OWN_ADDRESS_RESET;
            hosts_attached_reg <= ftpr_pkg::HOSTS_ATTACHED_RESET;
            broadcast_address_reg <= ftpr_pkg::BROADCAST_ADDRESS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ftpr_pkg::CFG_PORT_COUNT:
                    port_count_reg <= cfg_data[ftpr_pkg::COUNT_W-1:0];
                ftpr_pkg::CFG_ROUTER_LEVEL:
                    router_level_reg <= cfg_data[ftpr_pkg::LEVEL_W-1:0];
                ftpr_pkg::CFG_OWN_ADDRESS:
                    own_address_reg <= cfg_data;
                ftpr_pkg::CFG_HOSTS_ATTACHED:
                    hosts_attached_reg <= cfg_data[ftpr_pkg::HOSTS_W-1:0];
                ftpr_pkg::CFG_BROADCAST_ADDRESS:
                    broadcast_address_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            flood_left_reg <= '0;
            up_first_reg <= 1'b0;
            up_last_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            flood_left_reg <= flood_left_next;
            up_first_reg <= up_first_next;
            up_last_reg <= up_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flood_cur_reg <= flood_cur_next;
        arrive_reg <= arrive_next;
        out_port_reg <= out_port_next;
        status_reg <= status_next;
        last_reg <= last_next;
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.is_bcast = (opcode == ftpr_pkg::OP_INIT) && (destination == broadcast_address_reg);
    assign stat.flood_last = (flood_left_reg <= 7'd1);

    assign out_valid = out_valid_reg;
    assign out_port = out_port_reg;
    assign status = status_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

@@ sv/ftpr_ctrl.sv @@
// Controller state machine of the fat tree port router.
`default_nettype none

module ftpr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ftpr_pkg::dp_stat_t stat,
    output ftpr_pkg::dp_cmd_t       cmd
);

    ftpr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftpr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready = 1'b0;
        cmd = '0;
        case (state_reg)
            ftpr_pkg::ST_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    if (stat.is_bcast)
                    begin
                        cmd.start_flood = 1'b1;
                        state_next = ftpr_pkg::ST_FLOOD;
                    end
                    else
                    begin
                        cmd.take_unicast = 1'b1;
                    end
                end
            end
            ftpr_pkg::ST_FLOOD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_flood = 1'b1;
                    if (stat.flood_last)
                    begin
                        state_next = ftpr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ftpr_pkg::ST_IDLE;
            end
        endcase
    end

    // No input is taken while a flood is being walked.
    a_no_accept_in_flood: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ftpr_pkg::ST_FLOOD) |-> !in_ready)
        else $error("input accepted during flood");

    // A result is only loaded when the output register can take it.
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_unicast || cmd.emit_flood) |-> stat.out_free)
        else $error("output register overwritten");

    // At most one datapath command per cycle.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take_unicast, cmd.start_flood, cmd.emit_flood}))
        else $error("conflicting datapath commands");

    // Starting a flood always moves the controller into the flood walk.
    a_flood_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_flood |=> (state_reg == ftpr_pkg::ST_FLOOD))
        else $error("flood start without flood state");

endmodule

`default_nettype wire

@@ sv/fat_tree_port_router.sv @@
// Top level of the fat tree port router: controller and datapath.
`default_nettype none

// Output-port selector for one router of a three-level fat tree. No route table is
// stored: the port for a destination is decoded from the router level, its own address,
// the port count and the number of host ports, all set through the write port. The user
// must write them only while the block is idle, which the block itself does not enforce.
// An ordinary item gives one result beat, either the lowest matching port or a no-match
// status; such items are accepted every cycle while the output register drains. An init
// broadcast (opcode 1 with the broadcast address as destination) sets up the flood
// walker, which then issues one result beat per cycle while the single output register
// drains; an empty flood gives one status beat. The last beat of every item carries
// last_of_run. The MAX_PORTS parameter caps the ports in use, which never exceed 64.

module fat_tree_port_router #(
    parameter int MAX_PORTS = ftpr_pkg::MAX_PORTS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [ftpr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ftpr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             opcode,
    input  wire logic [ftpr_pkg::ADDR_W-1:0]      destination,
    input  wire logic [ftpr_pkg::PORT_W-1:0]      arrival_port,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [ftpr_pkg::PORT_W-1:0]           out_port,
    output logic [1:0]                            status,
    output logic                                  last_of_run
);

    // Commands from the controller and status back from the datapath.
    ftpr_pkg::dp_cmd_t  cmd;
    ftpr_pkg::dp_stat_t stat;

    // The controller decides when a beat is taken in, when a flood starts and when
    // each flood beat is loaded into the output register.
    ftpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, decodes unicast ports, walks the flood
    // list and owns the output register.
    ftpr_dp #(
        .MAX_PORTS (MAX_PORTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .destination  (destination),
        .arrival_port (arrival_port),
        .out_ready    (out_ready),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_port     (out_port),
        .status       (status),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

@@ tb/fat_tree_port_router_tb.sv @@
// Self-checking testbench for the fat tree port router: directed and random routing traffic.
`timescale 1ns / 100ps

// The testbench drives route requests through the valid/ready input channel and
// checks every result beat against its own decode of the port tables. Stimulus
// changes on the falling clock edge. Handshakes and result beats are sampled on
// the rising edge, so nothing depends on the order of events within a time step.
//
// The router keeps no route state besides its registers. The expected beats for
// one request therefore depend only on the register copy held here, and that copy
// is only changed while the block is drained.
module fat_tree_port_router_tb;
    import ftpr_pkg::*;

    // Ports in use never exceed the MAX_PORTS parameter or the 6-bit port field.
    localparam int PORT_CAP =
        (MAX_PORTS_DEFAULT < HW_PORT_LIMIT) ? MAX_PORTS_DEFAULT : HW_PORT_LIMIT;

    // Level code that selects no table at all.
    localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;

    // Table masks: full address, upstream byte 3, pod bytes 0..2, core bytes 0..1.
    localparam logic [ADDR_W-1:0] FULL_MASK = 32'hffff_ffff;
    localparam logic [ADDR_W-1:0] UPLINK_MASK = 32'hff00_0000;
    localparam logic [ADDR_W-1:0] POD_MASK = 32'h00ff_ffff;
    localparam logic [ADDR_W-1:0] CORE_MASK = 32'h0000_ffff;

    localparam int IDLE_PERCENT = 7;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 29;
    // The output is one register deep, so the settle wait covers any late beat.
    localparam int SETTLE_CYCLES = 8;
    // Time limit for the whole run, in nanoseconds.
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        status_t           code;
        logic              last;
    } route_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   opcode = OP_ROUTE;
    logic [ADDR_W-1:0]      destination = '0;
    logic [PORT_W-1:0]      arrival_port = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [PORT_W-1:0]      out_port;
    logic [1:0]             status;
    logic                   last_of_run;

    // Copy of the router registers, starting from their reset values.
    logic [COUNT_W-1:0] port_count_q = PORT_COUNT_RESET;
    logic [LEVEL_W-1:0] level_q = ROUTER_LEVEL_RESET;
    logic [ADDR_W-1:0]  own_address_q = OWN_ADDRESS_RESET;
    logic [HOSTS_W-1:0] hosts_q = HOSTS_ATTACHED_RESET;
    logic [ADDR_W-1:0]  bcast_q = BROADCAST_ADDRESS_RESET;

    // When set, neither the request side nor the result side idles.
    bit quiet_run = 1'b0;
    int mismatch_count = 0;

    // Result beats that accepted requests still owe, oldest first.
    route_beat_t pending_routes[$];

    fat_tree_port_router dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .destination(destination),
        .arrival_port(arrival_port),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_port(out_port),
        .status(status),
        .last_of_run(last_of_run)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a beat.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic route_beat_t make_beat(input logic [PORT_W-1:0] port,
                                              input status_t code, input logic last);
        route_beat_t beat;
        beat.port = port;
        beat.code = code;
        beat.last = last;
        return beat;
    endfunction

    // Appends one owed beat behind the ones already waiting.
    function automatic void expect_beat(input route_beat_t beat);
        pending_routes.insert(pending_routes.size(), beat);
    endfunction

    function automatic int ports_in_use();
        return (port_count_q > PORT_CAP) ? PORT_CAP : int'(port_count_q);
    endfunction

    function automatic int hosts_in_use(input int half);
        return (hosts_q < half) ? int'(hosts_q) : half;
    endfunction

    // Mask and match value of one port's table entry. Returns 0 when the level
    // selects no table, in which case nothing can match.
    function automatic bit port_entry(input int p, input int half, input int hosts,
                                      output logic [ADDR_W-1:0] mask,
                                      output logic [ADDR_W-1:0] value);
        int up;
        logic [7:0] up_byte;
        logic [7:0] p_byte;
        up = p - half + int'(BYTE_OFFSET);
        up_byte = up[7:0];
        p_byte = p[7:0];
        mask = FULL_MASK;
        value = '0;
        case (level_q)
            LEVEL_EDGE:
            begin
                if (p < hosts)
                begin
                    value = {p_byte + BYTE_OFFSET, own_address_q[23:0]};
                end
                else if (p >= half)
                begin
                    // Upstream ports select on byte 3 alone. Unwired host ports keep
                    // the full mask with a zero value, so they catch destination 0.
                    mask = UPLINK_MASK;
                    value = {up_byte, 24'h0};
                end
            end
            LEVEL_AGGREGATION:
            begin
                if (p < half)
                begin
                    mask = POD_MASK;
                    value = {8'h0, p_byte, own_address_q[15:0]};
                end
                else
                begin
                    mask = UPLINK_MASK;
                    value = {up_byte, 24'h0};
                end
            end
            LEVEL_CORE:
            begin
                mask = CORE_MASK;
                value = {16'h0, p_byte, CORE_NET_BYTE};
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    // Works out the beats one accepted request causes and queues them.
    function automatic void predict_routes(input logic op, input logic [ADDR_W-1:0] dest,
                                           input logic [PORT_W-1:0] arrive);
        int np;
        int half;
        int hosts;
        int from;
        int flood[$];
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] value;
        np = ports_in_use();
        half = np / 2;
        hosts = hosts_in_use(half);
        from = int'(arrive);
        if (op == OP_INIT && dest == bcast_q)
        begin
            // Init broadcast: flood under the level rules, never back out the
            // arrival port. An arrival port beyond the ports in use counts as upstream.
            case (level_q)
                LEVEL_EDGE:
                begin
                    for (int p = 0; p < hosts; p++)
                        if (p != from) flood.insert(flood.size(), p);
                    if (from < half) flood.insert(flood.size(), half);
                end
                LEVEL_AGGREGATION:
                begin
                    if (from < half)
                    begin
                        flood.insert(flood.size(), half);
                        for (int p = 0; p < half; p++)
                            if (p != from) flood.insert(flood.size(), p);
                    end
                    else
                    begin
                        for (int p = 0; p < half; p++) flood.insert(flood.size(), p);
                    end
                end
                LEVEL_CORE:
                begin
                    for (int p = 0; p < np; p++)
                        if (p != from) flood.insert(flood.size(), p);
                end
                default:
                begin
                end
            endcase
            if (flood.size() == 0)
            begin
                expect_beat(make_beat('0, STATUS_EMPTY, 1'b1));
            end
            else
            begin
                foreach (flood[k])
                    expect_beat(make_beat(PORT_W'(flood[k]), STATUS_PORT,
                                          k == flood.size() - 1));
            end
            return;
        end
        // Unicast: the lowest port whose masked compare matches wins.
        for (int p = 0; p < np; p++)
        begin
            if (port_entry(p, half, hosts, mask, value) && (dest & mask) == value)
            begin
                expect_beat(make_beat(PORT_W'(p), STATUS_PORT, 1'b1));
                return;
            end
        end
        expect_beat(make_beat('0, STATUS_NO_MATCH, 1'b1));
    endfunction

    // A destination that hits the entry of port p, with random don't-care bits.
    function automatic logic [ADDR_W-1:0] aimed_destination(input int p);
        int half;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] value;
        logic [ADDR_W-1:0] noise;
        half = ports_in_use() / 2;
        noise = $urandom;
        if (!port_entry(p, half, hosts_in_use(half), mask, value)) return noise;
        return (noise & ~mask) | value;
    endfunction

    // Mostly a port in use, sometimes any value the field allows.
    function automatic logic [PORT_W-1:0] random_arrival();
        int np;
        np = ports_in_use();
        if (np > 0 && $urandom_range(3) != 0) return PORT_W'($urandom_range(np - 1));
        return PORT_W'($urandom_range(HW_PORT_LIMIT - 1));
    endfunction

    task automatic report_mismatch(input string what, input route_beat_t want,
                                   input route_beat_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected port %0d status %0d last %0d, got %0d %0d %0d",
                     $time, what, want.port, want.code, want.last,
                     got.port, got.code, got.last);
    endtask

    // Every result beat is checked against the oldest expectation.
    always @(posedge clk)
    begin
        route_beat_t want;
        route_beat_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = make_beat(out_port, status_t'(status), last_of_run);
            if (pending_routes.size() == 0)
            begin
                want = make_beat('0, STATUS_PORT, 1'b0);
                report_mismatch("beat with nothing expected", want, got);
            end
            else
            begin
                want = pending_routes.pop_front();
                if (got.port !== want.port || got.code !== want.code ||
                    got.last !== want.last)
                    report_mismatch("wrong beat", want, got);
            end
        end
    end

    // The result side stalls now and then, except during quiet stretches.
    always @(negedge clk)
    begin
        out_ready <= quiet_run || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Offers one request beat and holds it until the router takes it. Valid is only
    // dropped when a gap is inserted, so back-to-back beats keep it high.
    task automatic offer_route(input logic op, input logic [ADDR_W-1:0] dest,
                               input logic [PORT_W-1:0] arrive);
        @(negedge clk);
        if (!quiet_run && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        destination <= dest;
        arrival_port <= arrive;
        do
            @(posedge clk);
        while (!in_ready);
        predict_routes(op, dest, arrive);
    endtask

    // Stops offering requests and waits until every owed beat has arrived.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_routes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_PORT_COUNT:        port_count_q = data[COUNT_W-1:0];
            CFG_ROUTER_LEVEL:      level_q = data[LEVEL_W-1:0];
            CFG_OWN_ADDRESS:       own_address_q = data;
            CFG_HOSTS_ATTACHED:    hosts_q = data[HOSTS_W-1:0];
            CFG_BROADCAST_ADDRESS: bcast_q = data;
            default:
            begin
            end
        endcase
    endtask

    // Drains the router, then rewrites every register.
    task automatic load_config(input int ports, input logic [LEVEL_W-1:0] level,
                               input logic [ADDR_W-1:0] own, input int hosts,
                               input logic [ADDR_W-1:0] bcast);
        settle_block();
        write_reg(CFG_PORT_COUNT, CFG_DATA_W'(ports));
        write_reg(CFG_ROUTER_LEVEL, CFG_DATA_W'(level));
        write_reg(CFG_OWN_ADDRESS, own);
        write_reg(CFG_HOSTS_ATTACHED, CFG_DATA_W'(hosts));
        write_reg(CFG_BROADCAST_ADDRESS, bcast);
    endtask

    // Reset table: 8 ports, edge level, own address 0, 4 host ports.
    task automatic test_reset_table();
        offer_route(OP_ROUTE, 32'h0200_0000, 6'd0);    // host port 0
        offer_route(OP_ROUTE, 32'h0500_0000, 6'd63);   // host port 3
        offer_route(OP_ROUTE, 32'h0300_1234, 6'd1);    // upstream port 5
        offer_route(OP_ROUTE, 32'hffff_ffff, 6'd0);    // no match
        offer_route(OP_INIT, 32'hffff_ffff, 6'd2);     // flood from a host port
        offer_route(OP_INIT, 32'hffff_ffff, 6'd63);    // flood from outside
        offer_route(OP_INIT, 32'h0200_0000, 6'd0);     // init data that is not a flood
    endtask

    // Unwired host ports catch destination 0; an oversized host count is clipped.
    task automatic test_host_ports();
        load_config(8, LEVEL_EDGE, 32'h1122_3344, 1, 32'hffff_ffff);
        offer_route(OP_ROUTE, 32'h0000_0000, 6'd0);
        offer_route(OP_ROUTE, 32'h0222_3344, 6'd5);
        load_config(8, LEVEL_EDGE, 32'h1122_3344, 63, 32'hffff_ffff);
        offer_route(OP_ROUTE, 32'h0522_3344, 6'd0);
        offer_route(OP_INIT, 32'hffff_ffff, 6'd7);
    endtask

    task automatic test_aggregation_level();
        load_config(8, LEVEL_AGGREGATION, 32'ha5c3_1e0f, 4, 32'hffff_ffff);
        offer_route(OP_ROUTE, 32'h7702_1e0f, 6'd0);    // pod port 2
        offer_route(OP_ROUTE, 32'h0400_0000, 6'd0);    // upstream port 6
        offer_route(OP_INIT, 32'hffff_ffff, 6'd1);
        offer_route(OP_INIT, 32'hffff_ffff, 6'd6);
    endtask

    // Core level at the largest port count gives the longest flood.
    task automatic test_core_level();
        load_config(64, LEVEL_CORE, 32'h0000_0000, 4, 32'hffff_ffff);
        offer_route(OP_ROUTE, 32'h1234_3f0a, 6'd0);
        offer_route(OP_ROUTE, 32'h0000_000b, 6'd0);
        offer_route(OP_INIT, 32'hffff_ffff, 6'd0);
        load_config(127, LEVEL_CORE, 32'hffff_ffff, 0, 32'hffff_ffff);
        offer_route(OP_ROUTE, 32'hffff_3f0a, 6'd63);
    endtask

    // Level 0 and port counts below 2.
    task automatic test_degenerate_sizes();
        load_config(8, LEVEL_NONE, 32'h0000_0000, 4, 32'hffff_ffff);
        offer_route(OP_ROUTE, 32'h0200_0000, 6'd0);
        offer_route(OP_INIT, 32'hffff_ffff, 6'd0);
        load_config(1, LEVEL_EDGE, 32'h0000_0000, 4, 32'hffff_ffff);
        offer_route(OP_ROUTE, 32'h02ab_cdef, 6'd0);
        offer_route(OP_INIT, 32'hffff_ffff, 6'd0);
        load_config(0, LEVEL_EDGE, 32'h0000_0000, 4, 32'hffff_ffff);
        offer_route(OP_ROUTE, 32'h0200_0000, 6'd0);
    endtask

    // A broadcast address of 0 only floods for init data.
    task automatic test_broadcast_address();
        load_config(2, LEVEL_EDGE, 32'h0000_0000, 32, 32'h0000_0000);
        offer_route(OP_INIT, 32'h0000_0000, 6'd0);
        offer_route(OP_ROUTE, 32'h0000_0000, 6'd0);
        offer_route(OP_INIT, 32'h0000_0000, 6'd1);
    endtask

    // Random phases, each with its own register setting. Most requests are aimed at a
    // real table entry or are floods; the rest are near misses and plain noise.
    task automatic test_random_traffic();
        int ports;
        int hosts;
        int pick;
        logic [LEVEL_W-1:0] level;
        logic [ADDR_W-1:0] own;
        logic [ADDR_W-1:0] bcast;
        logic op;
        logic [ADDR_W-1:0] dest;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            ports = $urandom_range(2, 16);
            level = LEVEL_W'($urandom_range(1, 3));
            own = $urandom;
            hosts = $urandom_range(0, 10);
            bcast = $urandom_range(1) ? 32'hffff_ffff : 32'($urandom);
            case (ph)
                0:
                begin
                    ports = 2;
                    level = LEVEL_EDGE;
                    own = '0;
                    hosts = 0;
                    bcast = '0;
                end
                1:
                begin
                    ports = 127;
                    level = LEVEL_CORE;
                    own = '1;
                    hosts = 63;
                    bcast = '1;
                end
                5:
                begin
                    ports = 64;
                    hosts = $urandom_range(0, 32);
                end
                9:
                begin
                    level = LEVEL_NONE;
                end
                default:
                begin
                end
            endcase
            load_config(ports, level, own, hosts, bcast);
            // One phase runs with no idling at all on either side.
            quiet_run = (ph == 3);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Midway through one phase the sender waits for the router to drain.
                if (ph == 6 && i == ITEMS_PER_PHASE / 2) settle_block();
                pick = $urandom_range(99);
                op = 1'($urandom_range(1));
                if (pick < 45)
                begin
                    dest = aimed_destination((ports_in_use() == 0) ? 0 :
                                             $urandom_range(ports_in_use() - 1));
                end
                else if (pick < 70)
                begin
                    op = OP_INIT;
                    dest = bcast_q;
                end
                else if (pick < 80)
                begin
                    op = OP_ROUTE;
                    dest = bcast_q;
                end
                else
                begin
                    dest = $urandom;
                end
                offer_route(op, dest, random_arrival());
            end
            quiet_run = 1'b0;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_table();
        test_host_ports();
        test_aggregation_level();
        test_core_level();
        test_degenerate_sizes();
        test_broadcast_address();
        test_random_traffic();

        settle_block();
        if (mismatch_count == 0 && pending_routes.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
